// ===== src/sps_pkg.sv =====
package sps_pkg;

   // Depth of the command queue between the parser and the result sequencer.
   localparam int QueueDepth = 4;

   // Result event codes.
   localparam logic [2:0] EV_REPLY = 3'd0;
   localparam logic [2:0] EV_ADDR  = 3'd1;
   localparam logic [2:0] EV_CONN  = 3'd2;
   localparam logic [2:0] EV_DATA  = 3'd3;
   localparam logic [2:0] EV_CLOSE = 3'd4;

   // Command codes handed from the parser to the sequencer.
   localparam logic [2:0] CMD_SINGLE      = 3'd0;
   localparam logic [2:0] CMD_CLOSE       = 3'd1;
   localparam logic [2:0] CMD_GREET       = 3'd2;
   localparam logic [2:0] CMD_REPLY_CLOSE = 3'd3;
   localparam logic [2:0] CMD_REPLY_CONN  = 3'd4;

   // Reply status codes.
   localparam logic [7:0] REP_SUCCESS     = 8'd0;
   localparam logic [7:0] REP_CMD_FAIL    = 8'd7;
   localparam logic [7:0] REP_ATYP_FAIL   = 8'd8;

   localparam logic [7:0] SOCKS_VERSION   = 8'd5;

   typedef struct packed {
      logic [2:0]  op;
      logic [2:0]  ev;
      logic [7:0]  data;
      logic [15:0] port;
      logic [1:0]  atype;
      logic [7:0]  alen;
   } cmd_type;

endpackage

// ===== src/sps_front.sv =====
module sps_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               kind,
   input  logic [7:0]         rx_byte,
   input  logic [8:0]         name_capacity,
   output logic               push,
   output sps_pkg::cmd_type   cmd
);
   import sps_pkg::*;

   localparam logic [2:0] PH_G_VER   = 3'd0;
   localparam logic [2:0] PH_G_NMETH = 3'd1;
   localparam logic [2:0] PH_G_METH  = 3'd2;
   localparam logic [2:0] PH_HDR     = 3'd3;
   localparam logic [2:0] PH_DLEN    = 3'd4;
   localparam logic [2:0] PH_ADDR    = 3'd5;
   localparam logic [2:0] PH_PORT    = 3'd6;
   localparam logic [2:0] PH_DATA    = 3'd7;

   localparam logic [7:0] ATYP_IPV4   = 8'd1;
   localparam logic [7:0] ATYP_DOMAIN = 8'd3;
   localparam logic [7:0] ATYP_IPV6   = 8'd4;
   localparam logic [7:0] CMD_CONNECT = 8'd1;

   logic [2:0]  phase_ff, phase_in;
   logic        version_ok_ff, version_ok_in;
   logic        header_ok_ff, header_ok_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic [1:0]  addr_kind_ff, addr_kind_in;
   logic [7:0]  addr_count_ff, addr_count_in;
   logic        name_too_long_ff, name_too_long_in;
   logic [15:0] port_value_ff, port_value_in;
   logic        closed_ff, closed_in;

   logic [7:0]  rem_dec;
   logic [15:0] port_next;

   assign rem_dec   = remaining_ff - 8'd1;
   assign port_next = {port_value_ff[7:0], rx_byte};

   always_comb begin
      phase_in         = phase_ff;
      version_ok_in    = version_ok_ff;
      header_ok_in     = header_ok_ff;
      remaining_in     = remaining_ff;
      addr_kind_in     = addr_kind_ff;
      addr_count_in    = addr_count_ff;
      name_too_long_in = name_too_long_ff;
      port_value_in    = port_value_ff;
      closed_in        = closed_ff;
      push             = 1'b0;
      cmd              = '0;

      if (accept && !closed_ff) begin
         if (kind) begin
            push      = 1'b1;
            cmd.op    = CMD_CLOSE;
            closed_in = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_G_VER: begin
                  version_ok_in = (rx_byte == SOCKS_VERSION);
                  phase_in      = PH_G_NMETH;
               end
               PH_G_NMETH: begin
                  if (!version_ok_ff) begin
                     push      = 1'b1;
                     cmd.op    = CMD_CLOSE;
                     closed_in = 1'b1;
                  end else if (rx_byte == 8'd0) begin
                     push         = 1'b1;
                     cmd.op       = CMD_GREET;
                     phase_in     = PH_HDR;
                     remaining_in = 8'd0;
                     header_ok_in = 1'b0;
                  end else begin
                     remaining_in = rx_byte;
                     phase_in     = PH_G_METH;
                  end
               end
               PH_G_METH: begin
                  remaining_in = rem_dec;
                  if (rem_dec == 8'd0) begin
                     push         = 1'b1;
                     cmd.op       = CMD_GREET;
                     phase_in     = PH_HDR;
                     header_ok_in = 1'b0;
                  end
               end
               PH_HDR: begin
                  if (remaining_ff == 8'd0) begin
                     header_ok_in = (rx_byte == SOCKS_VERSION);
                     remaining_in = 8'd1;
                  end else if (remaining_ff == 8'd1) begin
                     header_ok_in = header_ok_ff && (rx_byte == CMD_CONNECT);
                     remaining_in = 8'd2;
                  end else if (remaining_ff == 8'd2) begin
                     remaining_in = 8'd3;
                  end else begin
                     // Address type byte: the whole header is judged here.
                     name_too_long_in = 1'b0;
                     addr_count_in    = 8'd0;
                     port_value_in    = 16'd0;
                     if (!header_ok_ff) begin
                        push      = 1'b1;
                        cmd.op    = CMD_REPLY_CLOSE;
                        cmd.data  = REP_CMD_FAIL;
                        closed_in = 1'b1;
                     end else if (rx_byte == ATYP_IPV4) begin
                        addr_kind_in = 2'd0;
                        remaining_in = 8'd4;
                        phase_in     = PH_ADDR;
                     end else if (rx_byte == ATYP_DOMAIN) begin
                        addr_kind_in = 2'd1;
                        phase_in     = PH_DLEN;
                     end else if (rx_byte == ATYP_IPV6) begin
                        addr_kind_in = 2'd2;
                        remaining_in = 8'd16;
                        phase_in     = PH_ADDR;
                     end else begin
                        push      = 1'b1;
                        cmd.op    = CMD_REPLY_CLOSE;
                        cmd.data  = REP_ATYP_FAIL;
                        closed_in = 1'b1;
                     end
                  end
               end
               PH_DLEN: begin
                  name_too_long_in = ({1'b0, rx_byte} >= name_capacity);
                  remaining_in     = rx_byte;
                  addr_count_in    = 8'd0;
                  if (rx_byte == 8'd0) begin
                     remaining_in = 8'd2;
                     phase_in     = PH_PORT;
                  end else begin
                     phase_in = PH_ADDR;
                  end
               end
               PH_ADDR: begin
                  if (!name_too_long_ff) begin
                     push          = 1'b1;
                     cmd.op        = CMD_SINGLE;
                     cmd.ev        = EV_ADDR;
                     cmd.data      = rx_byte;
                     cmd.atype     = addr_kind_ff;
                     addr_count_in = addr_count_ff + 8'd1;
                  end
                  remaining_in = rem_dec;
                  if (rem_dec == 8'd0) begin
                     remaining_in  = 8'd2;
                     port_value_in = 16'd0;
                     phase_in      = PH_PORT;
                  end
               end
               PH_PORT: begin
                  port_value_in = port_next;
                  remaining_in  = rem_dec;
                  if (rem_dec == 8'd0) begin
                     push = 1'b1;
                     if (name_too_long_ff) begin
                        cmd.op    = CMD_CLOSE;
                        closed_in = 1'b1;
                     end else begin
                        cmd.op    = CMD_REPLY_CONN;
                        cmd.data  = REP_SUCCESS;
                        cmd.port  = port_next;
                        cmd.atype = addr_kind_ff;
                        cmd.alen  = addr_count_ff;
                        phase_in  = PH_DATA;
                     end
                  end
               end
               default: begin
                  push     = 1'b1;
                  cmd.op   = CMD_SINGLE;
                  cmd.ev   = EV_DATA;
                  cmd.data = rx_byte;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_G_VER;
         version_ok_ff    <= 1'b0;
         header_ok_ff     <= 1'b0;
         remaining_ff     <= 8'd0;
         addr_kind_ff     <= 2'd0;
         addr_count_ff    <= 8'd0;
         name_too_long_ff <= 1'b0;
         port_value_ff    <= 16'd0;
         closed_ff        <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         version_ok_ff    <= version_ok_in;
         header_ok_ff     <= header_ok_in;
         remaining_ff     <= remaining_in;
         addr_kind_ff     <= addr_kind_in;
         addr_count_ff    <= addr_count_in;
         name_too_long_ff <= name_too_long_in;
         port_value_ff    <= port_value_in;
         closed_ff        <= closed_in;
      end
   end

endmodule

// ===== src/sps_cmd_queue.sv =====
module sps_cmd_queue #(
   parameter int DEPTH = sps_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sps_pkg::cmd_type   push_cmd,
   input  logic               pop,
   output logic               head_valid,
   output sps_pkg::cmd_type   head_cmd,
   output logic               full
);
   import sps_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   cmd_type         entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == FullCnt);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/sps_back.sv =====
module sps_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  sps_pkg::cmd_type   cmd,
   output logic               cmd_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [2:0]         rsp_event,
   output logic [7:0]         rsp_byte,
   output logic [15:0]        rsp_port,
   output logic [1:0]         rsp_atype,
   output logic [7:0]         rsp_alen,
   output logic               rsp_tlast
);
   import sps_pkg::*;

   // Ten reply bytes, then the trailing close or connect item.
   localparam logic [3:0] TailIdx = 4'd10;

   logic [3:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [2:0]  event_ff, event_in;
   logic [7:0]  byte_ff, byte_in;
   logic [15:0] port_ff, port_in;
   logic [1:0]  atype_ff, atype_in;
   logic [7:0]  alen_ff, alen_in;
   logic        last_ff, last_in;
   logic        load;
   logic [7:0]  reply_byte;

   assign load = cmd_valid && (!valid_ff || rsp_tready);

   always_comb begin
      case (idx_ff)
         4'd0:    reply_byte = SOCKS_VERSION;
         4'd1:    reply_byte = cmd.data;
         4'd3:    reply_byte = 8'd1;
         default: reply_byte = 8'd0;
      endcase
   end

   always_comb begin
      event_in = EV_REPLY;
      byte_in  = 8'd0;
      port_in  = 16'd0;
      atype_in = 2'd0;
      alen_in  = 8'd0;
      last_in  = 1'b1;
      unique case (cmd.op) inside
         CMD_SINGLE: begin
            event_in = cmd.ev;
            byte_in  = cmd.data;
            atype_in = cmd.atype;
         end
         CMD_CLOSE: begin
            event_in = EV_CLOSE;
         end
         CMD_GREET: begin
            byte_in = (idx_ff == 4'd0) ? SOCKS_VERSION : 8'd0;
            last_in = (idx_ff == 4'd1);
         end
         CMD_REPLY_CLOSE, CMD_REPLY_CONN: begin
            last_in = (idx_ff == TailIdx);
            if (idx_ff != TailIdx) begin
               byte_in = reply_byte;
            end else if (cmd.op == CMD_REPLY_CLOSE) begin
               event_in = EV_CLOSE;
            end else begin
               event_in = EV_CONN;
               port_in  = cmd.port;
               atype_in = cmd.atype;
               alen_in  = cmd.alen;
            end
         end
         default: begin
            event_in = EV_CLOSE;
         end
      endcase
   end

   assign cmd_pop = load && last_in;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last_in ? 4'd0 : idx_ff + 4'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 4'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         event_ff <= event_in;
         byte_ff  <= byte_in;
         port_ff  <= port_in;
         atype_ff <= atype_in;
         alen_ff  <= alen_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_event  = event_ff;
   assign rsp_byte   = byte_ff;
   assign rsp_port   = port_ff;
   assign rsp_atype  = atype_ff;
   assign rsp_alen   = alen_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== src/socks5_handshake_parser_unit.sv =====
// Channel   Direction  Handshake                Payload
// req       in         req_tvalid/req_tready    tuser: kind, tdata: rx_byte
// rsp       out        rsp_tvalid/rsp_tready    tuser: event_res, tdata: reply fields, tlast
// csr       in         csr_valid/csr_ready      name_capacity (9 bits)
//
// One client byte is taken every cycle while the command queue has room.
// Each byte becomes at most one command; the sequencer turns a command into one
// result per cycle while rsp_tready is high, so a reply burst occupies it until
// its last result and the queue fills meanwhile. Reset is synchronous and active
// high and returns the parser to the greeting; name_capacity resets to 256.
// The csr channel is always ready.
module socks5_handshake_parser_unit #(
   parameter int QUEUE_DEPTH = sps_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte, [23:8] dest_port, [25:24] addr_type, [33:26] addr_length,
   // [39:34] zero
   output logic [39:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // [2:0] event_res
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data
);
   import sps_pkg::*;

   logic [8:0]  name_capacity_ff;
   logic        req_accept;
   logic        q_full;
   logic        q_push;
   cmd_type     q_push_cmd;
   logic        q_valid;
   cmd_type     q_head;
   logic        q_pop;
   logic [7:0]  out_byte;
   logic [15:0] out_port;
   logic [1:0]  out_atype;
   logic [7:0]  out_alen;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         name_capacity_ff <= 9'd256;
      end else if (csr_valid && csr_ready) begin
         name_capacity_ff <= csr_data;
      end
   end

   sps_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .kind          (req_tuser[0]),
      .rx_byte       (req_tdata),
      .name_capacity (name_capacity_ff),
      .push          (q_push),
      .cmd           (q_push_cmd)
   );

   sps_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head),
      .full       (q_full)
   );

   sps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd        (q_head),
      .cmd_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_event  (rsp_tuser),
      .rsp_byte   (out_byte),
      .rsp_port   (out_port),
      .rsp_atype  (out_atype),
      .rsp_alen   (out_alen),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, out_alen, out_atype, out_port, out_byte};

endmodule

// ===== bench/testbench.sv =====
module testbench;
   import sps_pkg::*;

   localparam int SETTLE_CYCLES  = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DATA_CHUNKS    = 5;
   localparam int CHUNK_ITEMS    = 100;
   localparam int NOISE_ITEMS    = 20;
   localparam int ITEM_TARGET    = 500;
   localparam int MAX_REPORTS    = 40;

   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   localparam logic [7:0] CMD_CONNECT    = 8'd1;
   localparam logic [7:0] METHOD_NO_AUTH = 8'd0;
   localparam logic [7:0] ATYP_IPV4      = 8'd1;
   localparam logic [7:0] ATYP_DOMAIN    = 8'd3;
   localparam logic [7:0] ATYP_IPV6      = 8'd4;

   localparam logic [1:0] TYPE_IPV4   = 2'd0;
   localparam logic [1:0] TYPE_DOMAIN = 2'd1;
   localparam logic [1:0] TYPE_IPV6   = 2'd2;

   typedef enum logic [2:0] {
      PH_GREET_VERSION,
      PH_GREET_COUNT,
      PH_GREET_METHODS,
      PH_REQ_HEADER,
      PH_NAME_LENGTH,
      PH_ADDRESS,
      PH_PORT,
      PH_PASSTHROUGH
   } parse_phase_type;

   typedef enum int {
      SC_BAD_GREETING,
      SC_BAD_HEADER,
      SC_BAD_ATYP,
      SC_NAME_TOO_LONG,
      SC_LINK_DROP,
      SC_CONNECT
   } session_kind_type;

   typedef struct {
      logic       kind;
      logic [7:0] value;
   } client_item_type;

   typedef struct {
      logic [2:0]  ev;
      logic [7:0]  data;
      logic [15:0] port;
      logic [1:0]  atype;
      logic [7:0]  alen;
      logic        last;
   } server_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic [0:0]  req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [8:0]  csr_data = 9'd0;

   client_item_type   pending_items[$];
   server_result_type expected_results[$];

   int   error_count = 0;
   int   results_seen = 0;
   int   items_sent = 0;
   int   idle_cycles = 0;
   int   req_gap = 0;
   int   rsp_stall = 0;
   int   step_results = 0;
   logic req_taken = 1'b0;
   logic gaps_enabled = 1'b1;

   // Shadow copy of the parser state.
   logic [8:0]      name_capacity = 9'd256;
   parse_phase_type parse_phase = PH_GREET_VERSION;
   logic            version_ok = 1'b0;
   logic            header_ok = 1'b0;
   logic [7:0]      remaining = 8'd0;
   logic [1:0]      addr_kind = TYPE_IPV4;
   logic [7:0]      addr_count = 8'd0;
   logic            name_too_long = 1'b0;
   logic [15:0]     port_value = 16'd0;
   logic            link_closed = 1'b0;

   socks5_handshake_parser_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!gaps_enabled || roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] random_octet();
      case ($urandom_range(0, 7))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hFF;
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   function automatic logic [7:0] any_but(logic [7:0] avoid);
      logic [7:0] pick;
      do begin
         pick = random_octet();
      end while (pick == avoid);
      return pick;
   endfunction

   function automatic logic [8:0] pick_capacity();
      case ($urandom_range(0, 6))
         0: begin
            return 9'd0;
         end
         1: begin
            return 9'd1;
         end
         2: begin
            return 9'd255;
         end
         3: begin
            return 9'd256;
         end
         4: begin
            return 9'd511;
         end
         default: begin
            return 9'($urandom_range(1, 256));
         end
      endcase
   endfunction

   function automatic void queue_item(logic kind, logic [7:0] value);
      pending_items.push_back('{kind, value});
   endfunction

   function automatic void post_result(logic [2:0] ev, logic [7:0] data, logic [15:0] port,
                                       logic [1:0] atype, logic [7:0] alen);
      expected_results.push_back('{ev, data, port, atype, alen, 1'b0});
      step_results++;
   endfunction

   // Ten-byte reply: version, status, reserved, IPv4 type, zero address and port.
   function automatic void post_reply(logic [7:0] status);
      post_result(EV_REPLY, SOCKS_VERSION, 16'd0, TYPE_IPV4, 8'd0);
      post_result(EV_REPLY, status, 16'd0, TYPE_IPV4, 8'd0);
      post_result(EV_REPLY, 8'd0, 16'd0, TYPE_IPV4, 8'd0);
      post_result(EV_REPLY, ATYP_IPV4, 16'd0, TYPE_IPV4, 8'd0);
      for (int i = 0; i < 6; i++) begin
         post_result(EV_REPLY, 8'd0, 16'd0, TYPE_IPV4, 8'd0);
      end
   endfunction

   function automatic void post_greeting_reply();
      post_result(EV_REPLY, SOCKS_VERSION, 16'd0, TYPE_IPV4, 8'd0);
      post_result(EV_REPLY, METHOD_NO_AUTH, 16'd0, TYPE_IPV4, 8'd0);
      parse_phase = PH_REQ_HEADER;
      remaining = 8'd0;
      header_ok = 1'b0;
   endfunction

   function automatic void post_close();
      post_result(EV_CLOSE, 8'd0, 16'd0, TYPE_IPV4, 8'd0);
      link_closed = 1'b1;
   endfunction

   // Works out the results that one accepted client transaction causes.
   function automatic void track_client_byte(logic kind, logic [7:0] b);
      server_result_type tail;
      step_results = 0;
      if (!link_closed) begin
         if (kind == KIND_CLOSE) begin
            post_close();
         end else begin
            case (parse_phase)
               PH_GREET_VERSION: begin
                  version_ok = (b == SOCKS_VERSION);
                  parse_phase = PH_GREET_COUNT;
               end
               PH_GREET_COUNT: begin
                  if (!version_ok) begin
                     post_close();
                  end else if (b == 8'd0) begin
                     post_greeting_reply();
                  end else begin
                     remaining = b;
                     parse_phase = PH_GREET_METHODS;
                  end
               end
               PH_GREET_METHODS: begin
                  remaining = remaining - 8'd1;
                  if (remaining == 8'd0) begin
                     post_greeting_reply();
                  end
               end
               PH_REQ_HEADER: begin
                  // The position within VER CMD RSV ATYP is kept in remaining.
                  if (remaining == 8'd0) begin
                     header_ok = (b == SOCKS_VERSION);
                     remaining = 8'd1;
                  end else if (remaining == 8'd1) begin
                     header_ok = header_ok && (b == CMD_CONNECT);
                     remaining = 8'd2;
                  end else if (remaining == 8'd2) begin
                     remaining = 8'd3;
                  end else begin
                     name_too_long = 1'b0;
                     addr_count = 8'd0;
                     port_value = 16'd0;
                     if (!header_ok) begin
                        post_reply(REP_CMD_FAIL);
                        post_close();
                     end else if (b == ATYP_IPV4) begin
                        addr_kind = TYPE_IPV4;
                        remaining = 8'd4;
                        parse_phase = PH_ADDRESS;
                     end else if (b == ATYP_DOMAIN) begin
                        addr_kind = TYPE_DOMAIN;
                        parse_phase = PH_NAME_LENGTH;
                     end else if (b == ATYP_IPV6) begin
                        addr_kind = TYPE_IPV6;
                        remaining = 8'd16;
                        parse_phase = PH_ADDRESS;
                     end else begin
                        post_reply(REP_ATYP_FAIL);
                        post_close();
                     end
                  end
               end
               PH_NAME_LENGTH: begin
                  name_too_long = ({1'b0, b} >= name_capacity);
                  remaining = b;
                  addr_count = 8'd0;
                  if (b == 8'd0) begin
                     remaining = 8'd2;
                     parse_phase = PH_PORT;
                  end else begin
                     parse_phase = PH_ADDRESS;
                  end
               end
               PH_ADDRESS: begin
                  if (!name_too_long) begin
                     post_result(EV_ADDR, b, 16'd0, addr_kind, 8'd0);
                     addr_count = addr_count + 8'd1;
                  end
                  remaining = remaining - 8'd1;
                  if (remaining == 8'd0) begin
                     remaining = 8'd2;
                     port_value = 16'd0;
                     parse_phase = PH_PORT;
                  end
               end
               PH_PORT: begin
                  port_value = {port_value[7:0], b};
                  remaining = remaining - 8'd1;
                  if (remaining == 8'd0) begin
                     if (name_too_long) begin
                        post_close();
                     end else begin
                        post_reply(REP_SUCCESS);
                        post_result(EV_CONN, 8'd0, port_value, addr_kind, addr_count);
                        parse_phase = PH_PASSTHROUGH;
                     end
                  end
               end
               default: begin
                  post_result(EV_DATA, b, 16'd0, TYPE_IPV4, 8'd0);
               end
            endcase
         end
      end
      if (step_results > 0) begin
         tail = expected_results.pop_back();
         tail.last = 1'b1;
         expected_results.push_back(tail);
      end
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("mismatch: %s", what);
      end
   endtask

   task automatic check_field(string field, int unsigned got, int unsigned want_value);
      if (got != want_value) begin
         report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                   results_seen, field, got, want_value));
      end
   endtask

   task automatic check_result();
      server_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("result %0d unexpected, event %0d byte %0h",
                                   results_seen, rsp_tuser, rsp_tdata[7:0]));
      end else begin
         want = expected_results.pop_front();
         check_field("event", 32'(rsp_tuser), 32'(want.ev));
         check_field("byte", 32'(rsp_tdata[7:0]), 32'(want.data));
         check_field("port", 32'(rsp_tdata[23:8]), 32'(want.port));
         check_field("addr_type", 32'(rsp_tdata[25:24]), 32'(want.atype));
         check_field("addr_length", 32'(rsp_tdata[33:26]), 32'(want.alen));
         check_field("padding", 32'(rsp_tdata[39:34]), 32'd0);
         check_field("last", 32'(rsp_tlast), 32'(want.last));
      end
      results_seen++;
   endtask

   // Client side: one transaction at a time from the pending queue.
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_items[0].value;
            req_tuser  <= pending_items[0].kind;
            req_gap = draw_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall = draw_gap();
      end
   end

   always @(posedge clock) begin
      logic progress;
      progress = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            track_client_byte(req_tuser[0], req_tdata);
            void'(pending_items.pop_front());
            req_taken = 1'b1;
            items_sent++;
            progress = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            progress = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            check_result();
            progress = 1'b1;
         end
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic wait_for_idle();
      while (pending_items.size() != 0 || req_tvalid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_name_capacity(logic [8:0] value);
      wait_for_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      name_capacity = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      session_kind_type scenario;
      int               roll;
      int               method_count;
      int               name_len;
      int               max_len;
      int               cut;
      int               noise_count;
      logic [8:0]       session_capacity;
      logic [7:0]       version_byte;
      logic [7:0]       command_byte;
      logic [7:0]       atyp_byte;

      roll = $urandom_range(0, 9);
      scenario = (roll >= int'(SC_CONNECT)) ? SC_CONNECT : session_kind_type'(roll);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The capacity only matters when the domain length arrives.
      if (scenario == SC_NAME_TOO_LONG) begin
         case ($urandom_range(0, 3))
            0: session_capacity = 9'd0;
            1: session_capacity = 9'd1;
            2: session_capacity = 9'($urandom_range(2, 32));
            default: session_capacity = 9'd255;
         endcase
         name_len = $urandom_range(int'(session_capacity), 255);
      end else begin
         session_capacity = pick_capacity();
         if (session_capacity == 9'd0) begin
            session_capacity = 9'd256;
         end
         max_len = (session_capacity > 9'd255) ? 255 : int'(session_capacity) - 1;
         name_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, max_len)
                                                : $urandom_range(0, (max_len < 12) ? max_len : 12);
      end
      write_name_capacity(pick_capacity());
      write_name_capacity(session_capacity);

      // Greeting.
      version_byte = (scenario == SC_BAD_GREETING) ? any_but(SOCKS_VERSION) : SOCKS_VERSION;
      roll = $urandom_range(0, 19);
      method_count = (roll < 5) ? 0 : (roll == 5) ? 255 : $urandom_range(1, 6);
      queue_item(KIND_BYTE, version_byte);
      queue_item(KIND_BYTE, 8'(method_count));
      for (int i = 0; i < method_count; i++) begin
         queue_item(KIND_BYTE, random_octet());
      end

      // Request header.
      version_byte = SOCKS_VERSION;
      command_byte = CMD_CONNECT;
      if (scenario == SC_BAD_HEADER) begin
         if ($urandom_range(0, 1) == 0) begin
            version_byte = any_but(SOCKS_VERSION);
            command_byte = random_octet();
         end else begin
            command_byte = any_but(CMD_CONNECT);
         end
      end
      if (scenario == SC_BAD_ATYP) begin
         case ($urandom_range(0, 2))
            0: atyp_byte = 8'd0;
            1: atyp_byte = 8'd2;
            default: begin
               do begin
                  atyp_byte = random_octet();
               end while (atyp_byte == ATYP_IPV4 || atyp_byte == ATYP_DOMAIN ||
                          atyp_byte == ATYP_IPV6);
            end
         endcase
      end else if (scenario == SC_NAME_TOO_LONG) begin
         atyp_byte = ATYP_DOMAIN;
      end else begin
         case ($urandom_range(0, 2))
            0: atyp_byte = ATYP_IPV4;
            1: atyp_byte = ATYP_DOMAIN;
            default: atyp_byte = ATYP_IPV6;
         endcase
      end
      queue_item(KIND_BYTE, version_byte);
      queue_item(KIND_BYTE, command_byte);
      queue_item(KIND_BYTE, random_octet());
      queue_item(KIND_BYTE, atyp_byte);

      // Address and port; after a rejected header these are ignored.
      if (atyp_byte == ATYP_IPV4) begin
         repeat (4) queue_item(KIND_BYTE, random_octet());
      end else if (atyp_byte == ATYP_IPV6) begin
         repeat (16) queue_item(KIND_BYTE, random_octet());
      end else if (atyp_byte == ATYP_DOMAIN) begin
         queue_item(KIND_BYTE, 8'(name_len));
         repeat (name_len) queue_item(KIND_BYTE, 8'($urandom_range(0, 255)));
      end
      queue_item(KIND_BYTE, random_octet());
      queue_item(KIND_BYTE, random_octet());

      // The queue was empty before this session, so nothing has been sent yet.
      if (scenario == SC_LINK_DROP) begin
         cut = $urandom_range(0, pending_items.size() - 1);
         while (pending_items.size() > cut) begin
            void'(pending_items.pop_back());
         end
         queue_item(KIND_CLOSE, 8'($urandom_range(0, 255)));
      end

      if (scenario == SC_CONNECT) begin
         for (int chunk = 0; chunk < DATA_CHUNKS; chunk++) begin
            write_name_capacity(pick_capacity());
            gaps_enabled = (chunk != 2) && ($urandom_range(0, 3) != 0);
            repeat (CHUNK_ITEMS) queue_item(KIND_BYTE, random_octet());
         end
      end

      // Wait out the session, then close the link and check that it stays silent
      // for the rest of the run.
      write_name_capacity(pick_capacity());
      gaps_enabled = 1'b1;
      queue_item(KIND_CLOSE, random_octet());
      noise_count = ITEM_TARGET - items_sent - 1;
      if (noise_count < NOISE_ITEMS) begin
         noise_count = NOISE_ITEMS;
      end
      repeat (noise_count) queue_item(1'($urandom_range(0, 1)), random_octet());

      wait_for_idle();
      if (error_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== socks5_handshake_parser_unit.f =====
src/sps_pkg.sv
src/sps_front.sv
src/sps_cmd_queue.sv
src/sps_back.sv
src/socks5_handshake_parser_unit.sv
bench/testbench.sv
